@@ rtl/ityh_pkg.sv @@
package ityh_pkg;

  localparam int CORDIC_STEPS_DEF = 16;

  // Widths inside the angle unit: operands, rotated vector, angle accumulator.
  localparam int IN_W = 26;
  localparam int XY_W = 46;
  localparam int Z_W = 33;
  localparam int H_W = 34;

  // Angles are in units of 2^-16 hundredths of a degree.
  localparam logic signed [Z_W-1:0] HALF_TURN = 33'sd1179648000;
  localparam logic signed [H_W-1:0] FULL_TURN = 34'sd2359296000;
  localparam logic signed [H_W-1:0] DECLINATION = 34'sd72089600;

  localparam logic [2:0] REG_GYRO_RANGE = 3'd0;
  localparam logic [2:0] REG_GYRO_OFFSET = 3'd1;
  localparam logic [2:0] REG_PERIOD = 3'd2;
  localparam logic [2:0] REG_MAG_ADJ_X = 3'd3;
  localparam logic [2:0] REG_MAG_ADJ_Y = 3'd4;

  localparam logic [2:0] RANGE_250 = 3'd0;
  localparam logic [2:0] RANGE_1000 = 3'd2;
  localparam logic [2:0] RANGE_2000 = 3'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_PREP,
    ST_ROLL,
    ST_PITCH,
    ST_PITCH_RUN,
    ST_HEAD,
    ST_FINISH,
    ST_OUT
  } state_t;

  // atan(2^-i) in angle units, rounded to nearest.
  function automatic logic [29:0] atan_tab(input logic [4:0] i);
    logic [29:0] v;
    case (i)
      5'd0: v = 30'd294912000;
      5'd1: v = 30'd174096719;
      5'd2: v = 30'd91987925;
      5'd3: v = 30'd46694507;
      5'd4: v = 30'd23437865;
      5'd5: v = 30'd11730358;
      5'd6: v = 30'd5866610;
      5'd7: v = 30'd2933484;
      5'd8: v = 30'd1466764;
      5'd9: v = 30'd733385;
      5'd10: v = 30'd366693;
      5'd11: v = 30'd183346;
      5'd12: v = 30'd91673;
      5'd13: v = 30'd45837;
      5'd14: v = 30'd22918;
      5'd15: v = 30'd11459;
      5'd16: v = 30'd5730;
      5'd17: v = 30'd2865;
      5'd18: v = 30'd1432;
      5'd19: v = 30'd716;
      5'd20: v = 30'd358;
      5'd21: v = 30'd179;
      5'd22: v = 30'd90;
      5'd23: v = 30'd45;
      5'd24: v = 30'd22;
      5'd25: v = 30'd11;
      5'd26: v = 30'd6;
      5'd27: v = 30'd3;
      5'd28: v = 30'd1;
      5'd29: v = 30'd1;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/imu_tilt_yaw_heading.sv @@
// Channel   Direction  Handshake          Payload
// input     in         in_valid/in_stall  accel_x/y/z, gyro_z, mag_x, mag_y
// output    out        out_valid/out_stall roll_cdeg, pitch_cdeg, yaw_cdeg, heading_deg
// config    in         APB psel/penable   gyro_range .. mag_adjust_y
//
// The single angle unit runs roll, pitch and heading in turn; below 23 CORDIC steps pitch waits
// for the 24-step square root. The yaw divider (57 steps) runs alongside. A new request is
// accepted only in idle, once the previous result has been registered. Reset clears the yaw
// sum and loads the register defaults.
// A result waiting on out_stall does not block acceptance; it holds back the next result.
module imu_tilt_yaw_heading import ityh_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] accel_x,
  input  logic signed [15:0] accel_y,
  input  logic signed [15:0] accel_z,
  input  logic signed [15:0] gyro_z,
  input  logic signed [15:0] mag_x,
  input  logic signed [15:0] mag_y,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] roll_cdeg,
  output logic signed [14:0] pitch_cdeg,
  output logic signed [31:0] yaw_cdeg,
  output logic [8:0]         heading_deg,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int DV_W = 57;

  logic [2:0]         gyro_range;
  logic signed [19:0] gyro_offset_z;
  logic [19:0]        sample_period_us;
  logic [7:0]         mag_adjust_x;
  logic [7:0]         mag_adjust_y;

  state_t state;
  state_t state_next;

  logic signed [15:0] ax, ay, az, gz, mx, my;
  logic               d_neg;
  logic [40:0]        prod;
  logic [31:0]        sumsq;

  logic [47:0] sq_rem, sq_res, sq_bit, sq_t;
  logic        sq_busy;

  logic [DV_W-1:0] dv_dvd;
  logic [20:0]     dv_rem;
  logic [21:0]     dv_trial;
  logic [5:0]      dv_cnt;
  logic            dv_busy;
  logic [20:0]     dv_div;
  logic [20:0]     dv_half;
  logic [43:0]     prod_num;

  logic                   cd_start;
  logic                   cd_done;
  logic signed [IN_W-1:0] cd_y, cd_x;
  logic signed [Z_W-1:0]  cd_z;

  logic signed [21:0] d;
  logic [20:0]        absd;
  logic signed [31:0] ay2, az2;
  logic signed [9:0]  adj_x, adj_y;
  logic signed [IN_W-1:0] hx, hy, py;
  logic signed [H_W-1:0]  rnd;
  logic signed [17:0]     ang_r;

  logic signed [15:0] roll;
  logic signed [14:0] pitch;
  logic signed [Z_W-1:0] head_z;
  logic signed [H_W-1:0] hc, h1, h2, h_wrap;
  logic signed [47:0] yaw_accum;
  logic signed [47:0] yaw_new;
  logic signed [48:0] delta, ysum;
  logic [28:0]        deg_prod;
  logic               out_free;

  assign pready = 1'b1;
  assign in_stall = (state != ST_IDLE);
  assign out_free = !out_valid || !out_stall;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      gyro_range <= 3'd1;
      gyro_offset_z <= '0;
      sample_period_us <= 20'd15000;
      mag_adjust_x <= 8'd128;
      mag_adjust_y <= 8'd128;
    end else if (psel && penable && pwrite) begin
      case (paddr[4:2])
        REG_GYRO_RANGE: gyro_range <= pwdata[2:0];
        REG_GYRO_OFFSET: gyro_offset_z <= pwdata[19:0];
        REG_PERIOD: sample_period_us <= pwdata[19:0];
        REG_MAG_ADJ_X: mag_adjust_x <= pwdata[7:0];
        REG_MAG_ADJ_Y: mag_adjust_y <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_GYRO_RANGE: prdata = {29'b0, gyro_range};
      REG_GYRO_OFFSET: prdata = {12'b0, gyro_offset_z};
      REG_PERIOD: prdata = {12'b0, sample_period_us};
      REG_MAG_ADJ_X: prdata = {24'b0, mag_adjust_x};
      REG_MAG_ADJ_Y: prdata = {24'b0, mag_adjust_y};
      default: prdata = '0;
    endcase
  end

  // Divisor is scale*10000 with the scale as a ratio; half of it rounds.
  always_comb begin
    case (gyro_range)
      RANGE_250: begin
        dv_div = 21'd1310000;
        dv_half = 21'd655000;
        prod_num = {3'b0, prod};
      end
      RANGE_1000: begin
        dv_div = 21'd1640000;
        dv_half = 21'd820000;
        prod_num = {1'b0, prod, 2'b0} + {3'b0, prod};
      end
      RANGE_2000: begin
        dv_div = 21'd820000;
        dv_half = 21'd410000;
        prod_num = {1'b0, prod, 2'b0} + {3'b0, prod};
      end
      default: begin
        dv_div = 21'd1310000;
        dv_half = 21'd655000;
        prod_num = {2'b0, prod, 1'b0};
      end
    endcase
  end

  assign d = {{2{gz[15]}}, gz, 4'b0} - {{2{gyro_offset_z[19]}}, gyro_offset_z};
  assign absd = d[21] ? 21'(-d) : d[20:0];
  assign ay2 = ay * ay;
  assign az2 = az * az;
  assign adj_x = $signed({2'b0, mag_adjust_x}) + 10'sd128;
  assign adj_y = $signed({2'b0, mag_adjust_y}) + 10'sd128;
  assign hx = IN_W'(mx) * IN_W'(adj_x);
  assign hy = IN_W'(my) * IN_W'(adj_y);
  assign py = -$signed({{(IN_W-24){ax[15]}}, ax, 8'b0});

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cd_start = 1'b0;
    cd_y = {{(IN_W-16){ay[15]}}, ay};
    cd_x = {{(IN_W-16){az[15]}}, az};
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: state_next = ST_PREP;
      ST_PREP: begin
        cd_start = 1'b1;
        state_next = ST_ROLL;
      end
      ST_ROLL: begin
        if (cd_done) begin
          state_next = ST_PITCH;
        end
      end
      ST_PITCH: begin
        cd_y = py;
        cd_x = {{(IN_W-24){1'b0}}, sq_res[23:0]};
        if (!sq_busy) begin
          cd_start = 1'b1;
          state_next = ST_PITCH_RUN;
        end
      end
      ST_PITCH_RUN: begin
        cd_y = hy;
        cd_x = hx;
        if (cd_done) begin
          cd_start = 1'b1;
          state_next = ST_HEAD;
        end
      end
      ST_HEAD: begin
        if (cd_done) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!dv_busy) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  ityh_cordic #(
    .STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk  (clk),
    .rst  (rst),
    .start(cd_start),
    .y_in (cd_y),
    .x_in (cd_x),
    .done (cd_done),
    .z    (cd_z)
  );

  // Round the angle to whole hundredths of a degree.
  assign rnd = {cd_z[Z_W-1], cd_z} + 34'sd32768;
  assign ang_r = rnd[33:16];

  assign sq_busy = (sq_bit != '0);
  assign sq_t = sq_res + sq_bit;
  assign dv_busy = (dv_cnt != '0);
  assign dv_trial = {dv_rem, dv_dvd[DV_W-1]};

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      ax <= accel_x;
      ay <= accel_y;
      az <= accel_z;
      gz <= gyro_z;
      mx <= mag_x;
      my <= mag_y;
    end
    if (state == ST_MUL) begin
      prod <= 41'(absd) * 41'(sample_period_us);
      d_neg <= d[21];
      sumsq <= $unsigned(ay2) + $unsigned(az2);
    end
    if (state == ST_ROLL && cd_done) begin
      if (ang_r > 18'sd18000) begin
        roll <= 16'sd18000;
      end else if (ang_r < -18'sd18000) begin
        roll <= -16'sd18000;
      end else begin
        roll <= ang_r[15:0];
      end
    end
    if (state == ST_PITCH_RUN && cd_done) begin
      if (ang_r > 18'sd9000) begin
        pitch <= 15'sd9000;
      end else if (ang_r < -18'sd9000) begin
        pitch <= -15'sd9000;
      end else begin
        pitch <= ang_r[14:0];
      end
    end
    if (state == ST_HEAD && cd_done) begin
      head_z <= cd_z;
    end
    if (state == ST_FINISH && !dv_busy) begin
      h_wrap <= (h2 > FULL_TURN) ? h2 - FULL_TURN : h2;
      if (ysum[48] != ysum[47]) begin
        yaw_new <= ysum[48] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
      end else begin
        yaw_new <= ysum[47:0];
      end
    end
  end

  // Digit-by-digit square root, one result bit per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      sq_bit <= '0;
    end else if (state == ST_PREP) begin
      sq_rem <= {sumsq, 16'b0};
      sq_res <= '0;
      sq_bit <= 48'h4000_0000_0000;
    end else if (sq_busy) begin
      if (sq_rem >= sq_t) begin
        sq_rem <= sq_rem - sq_t;
        sq_res <= (sq_res >> 1) + sq_bit;
      end else begin
        sq_res <= sq_res >> 1;
      end
      sq_bit <= sq_bit >> 2;
    end
  end

  // Restoring divider; the quotient shifts in where the dividend shifts out.
  always_ff @(posedge clk) begin
    if (rst) begin
      dv_cnt <= '0;
    end else if (state == ST_PREP) begin
      dv_dvd <= {1'b0, prod_num, 12'b0} + DV_W'(dv_half);
      dv_rem <= '0;
      dv_cnt <= 6'(DV_W);
    end else if (dv_busy) begin
      if (dv_trial >= {1'b0, dv_div}) begin
        dv_rem <= 21'(dv_trial - {1'b0, dv_div});
        dv_dvd <= {dv_dvd[DV_W-2:0], 1'b1};
      end else begin
        dv_rem <= dv_trial[20:0];
        dv_dvd <= {dv_dvd[DV_W-2:0], 1'b0};
      end
      dv_cnt <= dv_cnt - 1'b1;
    end
  end

  assign delta = d_neg ? -$signed({1'b0, dv_dvd[47:0]}) : $signed({1'b0, dv_dvd[47:0]});
  assign ysum = {yaw_accum[47], yaw_accum} + delta;

  always_comb begin
    if (head_z > HALF_TURN) begin
      hc = {HALF_TURN[Z_W-1], HALF_TURN};
    end else if (head_z < -HALF_TURN) begin
      hc = -{HALF_TURN[Z_W-1], HALF_TURN};
    end else begin
      hc = {head_z[Z_W-1], head_z};
    end
    h1 = hc[H_W-1] ? hc + FULL_TURN : hc;
    h2 = h1 + DECLINATION;
  end

  // Whole degrees: divide by 100 through the reciprocal 5243/2^19.
  assign deg_prod = 29'(h_wrap[31:16]) * 29'd5243;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      yaw_accum <= '0;
    end else begin
      if (state == ST_OUT && out_free) begin
        out_valid <= 1'b1;
        yaw_accum <= yaw_new;
        roll_cdeg <= roll;
        pitch_cdeg <= pitch;
        yaw_cdeg <= yaw_new[47:16];
        heading_deg <= deg_prod[27:19];
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/ityh_cordic.sv @@
module ityh_cordic import ityh_pkg::*; #(
  parameter int STEPS = CORDIC_STEPS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic signed [IN_W-1:0] y_in,
  input  logic signed [IN_W-1:0] x_in,
  output logic                   done,
  output logic signed [Z_W-1:0]  z
);

  localparam int CNT_W = $clog2(STEPS);

  logic                   busy;
  logic [CNT_W-1:0]       cnt;
  logic signed [XY_W-1:0] x;
  logic signed [XY_W-1:0] y;
  logic signed [IN_W-1:0] xa;
  logic signed [IN_W-1:0] ya;
  logic signed [XY_W-1:0] dx;
  logic signed [XY_W-1:0] dy;
  logic signed [Z_W-1:0]  ang;

  // A vector in the left half plane is turned by half a turn first.
  assign xa = x_in[IN_W-1] ? -x_in : x_in;
  assign ya = x_in[IN_W-1] ? -y_in : y_in;
  assign dx = y >>> cnt;
  assign dy = x >>> cnt;
  assign ang = $signed({{(Z_W-30){1'b0}}, atan_tab(5'(cnt))});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        if (y_in == '0) begin
          z <= x_in[IN_W-1] ? HALF_TURN : '0;
          done <= 1'b1;
        end else begin
          busy <= 1'b1;
          cnt <= '0;
          x <= {{(XY_W-IN_W-16){xa[IN_W-1]}}, xa, 16'b0};
          y <= {{(XY_W-IN_W-16){ya[IN_W-1]}}, ya, 16'b0};
          if (x_in[IN_W-1]) begin
            z <= y_in[IN_W-1] ? -HALF_TURN : HALF_TURN;
          end else begin
            z <= '0;
          end
        end
      end else if (busy) begin
        if (y > 0) begin
          x <= x + dx;
          y <= y - dy;
          z <= z + ang;
        end else begin
          x <= x - dx;
          y <= y + dy;
          z <= z - ang;
        end
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ tb/imu_tilt_yaw_heading_chk.sv @@
module imu_tilt_yaw_heading_chk import ityh_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [15:0] accel_x,
  input  logic signed [15:0] accel_y,
  input  logic signed [15:0] accel_z,
  input  logic signed [15:0] gyro_z,
  input  logic signed [15:0] mag_x,
  input  logic signed [15:0] mag_y,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [15:0] roll_cdeg,
  input  logic signed [14:0] pitch_cdeg,
  input  logic signed [31:0] yaw_cdeg,
  input  logic [8:0]         heading_deg,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  output int                 errors,
  output int                 pending
);

  localparam longint HALF = 64'sd1179648000;
  localparam longint FULL = 64'sd2359296000;
  localparam longint DEG1 = 64'sd6553600;
  localparam longint DECL = 64'sd72089600;
  localparam longint SUM_MAX = 64'sd140737488355327;
  localparam longint SUM_MIN = -64'sd140737488355328;

  typedef struct packed {
    logic signed [15:0] roll;
    logic signed [14:0] pitch;
    logic signed [31:0] yaw;
    logic [8:0]         heading;
  } attitude_t;

  logic [2:0]         range_q;
  logic signed [19:0] offset_q;
  logic [19:0]        period_q;
  logic [7:0]         adj_x_q, adj_y_q;
  longint             yaw_sum;
  attitude_t          attitude_q[$];

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint root_floor(longint n);
    longint r, lo, hi, m;
    lo = 0;
    hi = 64'd4294967296;
    while (lo < hi) begin
      m = (lo + hi + 1) / 2;
      if (m * m <= n) lo = m;
      else hi = m - 1;
    end
    r = lo;
    return r;
  endfunction

  function automatic longint vector_angle(longint y, longint x);
    longint z, dx, dy;
    z = 0;
    if (y == 0) return (x < 0) ? HALF : 0;
    if (x < 0) begin
      z = (y > 0) ? HALF : -HALF;
      x = -x;
      y = -y;
    end
    x = x * 65536;
    y = y * 65536;
    for (int i = 0; i < CORDIC_STEPS_DEF && i < 32; i++) begin
      dx = floor_shr(y, i);
      dy = floor_shr(x, i);
      if (y > 0) begin
        x += dx; y -= dy; z += longint'(atan_tab(5'(i)));
      end else begin
        x -= dx; y += dy; z -= longint'(atan_tab(5'(i)));
      end
    end
    return z;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic attitude_t predict_attitude(longint ax, longint ay, longint az,
                                                 longint gz, longint mx, longint my);
    attitude_t a;
    longint sq, num, den, d, mag, h;
    a.roll = 16'(clip(floor_shr(vector_angle(ay, az) + 32768, 16), -18000, 18000));
    sq = root_floor((ay * ay + az * az) * 65536);
    a.pitch = 15'(clip(floor_shr(vector_angle(-ax * 256, sq) + 32768, 16), -9000, 9000));
    case (range_q)
      RANGE_250:  begin num = 1; den = 131; end
      RANGE_1000: begin num = 5; den = 164; end
      RANGE_2000: begin num = 5; den = 82; end
      default:    begin num = 2; den = 131; end
    endcase
    d = gz * 16 - longint'(offset_q);
    mag = (d < 0 ? -d : d) * longint'(period_q) * num * 4096;
    mag = (mag + den * 5000) / (den * 10000);
    yaw_sum = clip(yaw_sum + (d < 0 ? -mag : mag), SUM_MIN, SUM_MAX);
    a.yaw = 32'(floor_shr(yaw_sum, 16));
    h = vector_angle(my * (longint'(adj_y_q) + 128), mx * (longint'(adj_x_q) + 128));
    h = clip(h, -HALF, HALF);
    if (h < 0) h += FULL;
    h += DECL;
    if (h > FULL) h -= FULL;
    a.heading = 9'(h / DEG1);
    return a;
  endfunction

  assign pending = attitude_q.size();

  always @(posedge clk) begin
    attitude_t want;
    if (rst) begin
      range_q <= 3'd1;
      offset_q <= '0;
      period_q <= 20'd15000;
      adj_x_q <= 8'd128;
      adj_y_q <= 8'd128;
      yaw_sum = 0;
      attitude_q.delete();
      errors <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_GYRO_RANGE:  range_q <= pwdata[2:0];
          REG_GYRO_OFFSET: offset_q <= pwdata[19:0];
          REG_PERIOD:      period_q <= pwdata[19:0];
          REG_MAG_ADJ_X:   adj_x_q <= pwdata[7:0];
          REG_MAG_ADJ_Y:   adj_y_q <= pwdata[7:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        attitude_q.push_back(predict_attitude(accel_x, accel_y, accel_z,
                                              gyro_z, mag_x, mag_y));
      if (out_valid && !out_stall) begin
        if (attitude_q.size() == 0) begin
          $display("%0t: unexpected result roll=%0d pitch=%0d yaw=%0d heading=%0d",
                   $time, roll_cdeg, pitch_cdeg, yaw_cdeg, heading_deg);
          errors <= errors + 1;
        end else begin
          want = attitude_q.pop_front();
          if (want.roll !== roll_cdeg || want.pitch !== pitch_cdeg ||
              want.yaw !== yaw_cdeg || want.heading !== heading_deg) begin
            $display("%0t: expected roll=%0d pitch=%0d yaw=%0d heading=%0d", $time,
                     want.roll, want.pitch, want.yaw, want.heading);
            $display("%0t: actual   roll=%0d pitch=%0d yaw=%0d heading=%0d", $time,
                     roll_cdeg, pitch_cdeg, yaw_cdeg, heading_deg);
            errors <= errors + 1;
          end
        end
      end
    end
  end
endmodule

@@ tb/imu_tilt_yaw_heading_tb.sv @@
module imu_tilt_yaw_heading_tb import ityh_pkg::*; ();

  logic               clk, rst;
  logic               in_valid, in_stall, out_valid, out_stall;
  logic signed [15:0] accel_x, accel_y, accel_z, gyro_z, mag_x, mag_y;
  logic signed [15:0] roll_cdeg;
  logic signed [14:0] pitch_cdeg;
  logic signed [31:0] yaw_cdeg;
  logic [8:0]         heading_deg;
  logic               psel, penable, pwrite, pready;
  logic [4:0]         paddr;
  logic [31:0]        pwdata, prdata;
  int                 errors, pending;
  int                 send_idle, recv_idle, quiet;

  imu_tilt_yaw_heading dut (.*);
  imu_tilt_yaw_heading_chk chk (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Random receiver stall at each falling edge.
  always @(negedge clk) out_stall <= ($urandom_range(99) < recv_idle);

  // Watchdog over cycles where no request or result moves.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > 200000) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(negedge clk);
    penable <= 1;
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  task automatic drain;
    in_valid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  // The valid stays high after acceptance until the next call idles or drives a new request.
  task automatic send_sample(logic [15:0] ax, ay, az, gz, mx, my);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    accel_x <= ax; accel_y <= ay; accel_z <= az;
    gyro_z <= gz; mag_x <= mx; mag_y <= my;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [15:0] pick_word();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($signed($urandom_range(40)) - 20);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_samples(int n);
    repeat (n) send_sample(pick_word(), pick_word(), pick_word(), pick_word(),
                           pick_word(), pick_word());
  endtask

  initial begin
    rst = 1; in_valid = 0; out_stall = 0; psel = 0; penable = 0; pwrite = 0;
    paddr = 0; pwdata = 0; accel_x = 0; accel_y = 0; accel_z = 0; gyro_z = 0;
    mag_x = 0; mag_y = 0; send_idle = 18; recv_idle = 50;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Zero operands, axis cases, both extremes, and the declination wrap.
    send_sample(0, 0, 0, 0, 0, 0);
    send_sample(0, 0, -100, 100, -100, 0);
    send_sample(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_sample(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    send_sample(16'h7fff, 0, 0, 0, 0, 16'h8000);
    send_sample(16'h8000, 0, 1, 0, 1000, -192);
    send_sample(1, -1, 0, -1, 0, 1);
    send_sample(100, 100, 100, 0, 100, -100);
    drain();

    for (int r = 0; r < 8; r++) begin
      write_reg(REG_GYRO_RANGE, r);
      send_sample(0, 1000, 1000, 16'h7fff, 300, 300);
      drain();
    end
    write_reg(REG_GYRO_OFFSET, 32'h0007ffff);
    write_reg(REG_PERIOD, 0);
    write_reg(REG_MAG_ADJ_X, 0);
    write_reg(REG_MAG_ADJ_Y, 255);
    send_sample(5, 6, 7, 16'h8000, 500, 500);
    send_sample(5, 6, 7, 16'h7fff, -500, 500);
    drain();

    // Large period and offset give large yaw steps in one direction.
    write_reg(REG_GYRO_RANGE, RANGE_250);
    write_reg(REG_GYRO_OFFSET, 32'h00080000);
    write_reg(REG_PERIOD, 1000000);
    write_reg(REG_MAG_ADJ_X, 255);
    write_reg(REG_MAG_ADJ_Y, 0);
    repeat (40) send_sample(pick_word(), pick_word(), pick_word(), 16'h7fff,
                            pick_word(), pick_word());
    random_samples(200);
    drain();

    send_idle = 50; recv_idle = 18;
    write_reg(REG_GYRO_RANGE, $urandom_range(7));
    write_reg(REG_GYRO_OFFSET, $urandom);
    write_reg(REG_PERIOD, $urandom_range(1, 1000000));
    write_reg(REG_MAG_ADJ_X, $urandom);
    write_reg(REG_MAG_ADJ_Y, $urandom);
    random_samples(300);
    drain();

    send_idle = 0; recv_idle = 0;
    write_reg(REG_GYRO_RANGE, RANGE_2000);
    write_reg(REG_GYRO_OFFSET, $urandom);
    write_reg(REG_PERIOD, 1);
    write_reg(REG_MAG_ADJ_X, 128);
    write_reg(REG_MAG_ADJ_Y, 128);
    random_samples(340);
    drain();

    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule

@@ sim.f @@
rtl/ityh_pkg.sv
rtl/ityh_cordic.sv
rtl/imu_tilt_yaw_heading.sv
tb/imu_tilt_yaw_heading_chk.sv
tb/imu_tilt_yaw_heading_tb.sv
